/* rtl/btcf_pkg.sv */
// Shared types, constants and codes of the bus trace change filter.
`timescale 1ns / 1ps
package btcf_pkg;

    // Width of the per-address folding store index (8 to 16).
    localparam int ADDR_BITS   = 16;
    localparam int STORE_DEPTH = 1 << ADDR_BITS;
    // Number of extra address ranges that take part in matching (1 to 3).
    localparam int NUM_RANGES  = 3;
    // Number of range registers on the configuration port.
    localparam int RANGE_REGS  = 3;
    // Depth of the record queue in front of the output channel.
    localparam int OUTQ_DEPTH  = 4;

    // Fixed address window and reset value of the line cap.
    localparam logic [15:0] WIN_LO    = 16'h0800;
    localparam logic [15:0] WIN_HI    = 16'h0FFF;
    localparam logic [31:0] CAP_RESET = 32'd5_000_000;
    localparam logic [31:0] SAT_MAX   = 32'hFFFF_FFFF;

    // Trace mode codes; the remaining codes trace reads and writes.
    localparam logic [1:0] TM_WRITES_ONLY = 2'd1;
    localparam logic [1:0] TM_READS_ONLY  = 2'd2;

    // Direction bit 0 set means a read.
    localparam int DIR_READ_BIT = 0;

    // Record kinds.
    localparam logic [1:0] KIND_EVENT   = 2'd0;
    localparam logic [1:0] KIND_SUMMARY = 2'd1;
    localparam logic [1:0] KIND_CAP     = 2'd2;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_TRACE_MODE  = 3'd0,
        REG_ONLY_LISTED = 3'd1,
        REG_RAW_MODE    = 3'd2,
        REG_LINE_CAP    = 3'd3,
        REG_RANGE_COUNT = 3'd4,
        REG_RANGE_A     = 3'd5,
        REG_RANGE_B     = 3'd6,
        REG_RANGE_C     = 3'd7
    } t_cfg_idx;

    // Configuration register file contents.
    typedef struct packed {
        logic [1:0]  trace_mode;
        logic        only_listed;
        logic        raw_mode;
        logic [31:0] line_cap;
        logic [1:0]  range_count;
        logic [RANGE_REGS-1:0][31:0] ranges;
    } t_cfg;

    // One bus access.
    typedef struct packed {
        logic [1:0]  direction;
        logic [15:0] word_address;
        logic [15:0] new_value;
        logic [15:0] prior_value;
        logic [31:0] context_pc;
        logic [31:0] frame_number;
        logic [31:0] instr_count;
    } t_acc;

    // One trace record.
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [1:0]  rec_direction;
        logic [15:0] rec_address;
        logic [15:0] rec_old_value;
        logic [15:0] rec_value;
        logic [31:0] rec_context;
        logic [31:0] rec_frame;
        logic [31:0] rec_instr;
        logic [31:0] rec_repeats;
        logic        rec_last;
    } t_rec;

    // One folding entry of the per-address store.
    typedef struct packed {
        logic        seen;
        logic [31:0] run;
        logic [1:0]  dir;
        logic [31:0] ctx;
        logic [15:0] value;
    } t_entry;

    // Records handed from the update stage to the output queue.
    typedef struct packed {
        logic [1:0] count;
        t_rec       rec0;
        t_rec       rec1;
    } t_push;

endpackage

/* rtl/btcf_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module btcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/btcf_match.sv */
// Direction and address filter of the bus trace change filter.
`timescale 1ns / 1ps
module btcf_match (
    input  btcf_pkg::t_cfg  i_cfg,
    input  logic [1:0]      i_direction,
    input  logic [15:0]     i_address,
    output logic            o_pass
);

    import btcf_pkg::*;

    logic        is_rd;
    logic        dir_ok;
    logic        range_hit;
    logic        win_hit;
    logic [15:0] b0;
    logic [15:0] b1;
    logic [15:0] lo;
    logic [15:0] hi;

    // Direction enable from the trace mode.
    assign is_rd  = i_direction[DIR_READ_BIT];
    assign dir_ok = !(!is_rd && (i_cfg.trace_mode == TM_READS_ONLY)) &&
                    !(is_rd && (i_cfg.trace_mode == TM_WRITES_ONLY));

    // Each active range is compared in parallel; bounds may come in any order.
    always_comb begin
        range_hit = 1'b0;
        b0 = '0;
        b1 = '0;
        lo = '0;
        hi = '0;
        for (int i = 0; i < NUM_RANGES; i++) begin
            b0 = i_cfg.ranges[i][15:0];
            b1 = i_cfg.ranges[i][31:16];
            lo = (b0 < b1) ? b0 : b1;
            hi = (b0 < b1) ? b1 : b0;
            if ((i < int'(i_cfg.range_count)) && (i_address >= lo) && (i_address <= hi)) begin
                range_hit = 1'b1;
            end
        end
    end

    // The fixed window counts unless only the listed ranges are wanted.
    assign win_hit = !i_cfg.only_listed && (i_address >= WIN_LO) && (i_address <= WIN_HI);

    assign o_pass = dir_ok && (range_hit || win_hit);

endmodule

/* rtl/btcf_outq.sv */
// Record queue between the update stage and the output channel.
`timescale 1ns / 1ps
module btcf_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  btcf_pkg::t_push  i_push,
    output logic             o_space2,
    output logic             o_valid,
    input  logic             i_stall,
    output btcf_pkg::t_rec   o_data
);

    import btcf_pkg::*;

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

    t_rec             r_mem [OUTQ_DEPTH];
    logic [PTR_W-1:0] r_head;
    logic [PTR_W-1:0] r_tail;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] tail1;
    logic             pop;

    assign pop      = o_valid && !i_stall;
    assign tail1    = r_tail + PTR_W'(1);
    assign o_valid  = (r_count != '0);
    assign o_data   = r_mem[r_head];
    // Room for two records regardless of what leaves this cycle.
    assign o_space2 = (r_count <= CNT_W'(OUTQ_DEPTH - 2));

    // Record storage: up to two writes per cycle at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_tail] <= i_push.rec0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[tail1] <= i_push.rec1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + PTR_W'(i_push.count);
            r_count <= r_count + CNT_W'(i_push.count) - CNT_W'(pop);
            if (pop) begin
                r_head <= r_head + PTR_W'(1);
            end
        end
    end

endmodule

/* rtl/bus_trace_change_filter.sv */
// Top level of the bus trace change filter: configuration, folding store update, output.
`timescale 1ns / 1ps
// Usage
//   Input channel: one bus access per transfer on i_in_data (i_in_valid / o_in_stall).
//   Output channel: one trace record per transfer on o_out_data (o_out_valid / i_out_stall).
//   An access gives zero, one or two records; rec_last marks the final one.
//   Configuration registers are to be written through i_cfg_we / i_cfg_idx /
//   i_cfg_data while the block is idle; the block itself does not enforce this.
// Pipeline and throughput
//   An access is held in the update stage register and its records are queued
//   for output. One access is taken every cycle while the queue has room for two
//   records. The folding store is a single memory read in the acceptance cycle and
//   written back from the update stage, with the last write forwarded when the
//   next access hits the same entry. The output port bounds the rate: it moves one
//   record per cycle unless stalled; a summary and its event are two transfers.
// Reset
//   After reset the folding store is swept clear, one entry per cycle, over all
//   2^ADDR_BITS entries; o_in_stall is high during the sweep.
//   Configuration writes are taken during the sweep.
// Stalls
//   A four-record queue drives the output; when it cannot take two more records
//   the update stage holds and o_in_stall rises.
module bus_trace_change_filter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  btcf_pkg::t_acc  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output btcf_pkg::t_rec  o_out_data
);

    import btcf_pkg::*;

    localparam int EW = $bits(t_entry);

    t_cfg                 r_cfg;
    logic                 r_clr_busy;
    logic [ADDR_BITS-1:0] r_clr_idx;
    logic                 r_s1_valid;
    t_acc                 r_s1;
    logic [31:0]          r_cnt;
    logic [31:0]          n_cnt;
    logic                 r_fwd_valid;
    logic [ADDR_BITS-1:0] r_fwd_idx;
    t_entry               r_fwd_data;

    logic                 in_accept;
    logic                 s1_fire;
    logic                 q_space2;
    logic                 pass;
    logic [ADDR_BITS-1:0] s1_idx;
    logic [EW-1:0]        ram_rdata;
    t_entry               cur;
    t_entry               upd;
    logic                 upd_we;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    t_entry               ram_wdata;
    t_push                push;
    t_rec                 ev;
    logic                 is_wr;
    logic                 changing;
    logic                 cap_on;
    logic                 fold;
    logic [31:0]          cnt_inc;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trace_mode  <= '0;
            r_cfg.only_listed <= 1'b0;
            r_cfg.raw_mode    <= 1'b0;
            r_cfg.line_cap    <= CAP_RESET;
            r_cfg.range_count <= '0;
            r_cfg.ranges      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                REG_TRACE_MODE:  r_cfg.trace_mode  <= i_cfg_data[1:0];
                REG_ONLY_LISTED: r_cfg.only_listed <= i_cfg_data[0];
                REG_RAW_MODE:    r_cfg.raw_mode    <= i_cfg_data[0];
                REG_LINE_CAP:    r_cfg.line_cap    <= i_cfg_data;
                REG_RANGE_COUNT: r_cfg.range_count <= i_cfg_data[1:0];
                REG_RANGE_A:     r_cfg.ranges[0]   <= i_cfg_data;
                REG_RANGE_B:     r_cfg.ranges[1]   <= i_cfg_data;
                REG_RANGE_C:     r_cfg.ranges[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input handshake: the store read is issued as the access is taken.
    assign s1_fire    = r_s1_valid && q_space2;
    assign o_in_stall = r_clr_busy || (r_s1_valid && !s1_fire);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign s1_idx     = r_s1.word_address[ADDR_BITS-1:0];

    // Update stage register and clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
            r_cnt      <= '0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + ADDR_BITS'(1);
                if (r_clr_idx == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1 <= i_in_data;
        end
    end

    // Folding store.
    btcf_ram #(
        .WIDTH (EW),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (i_in_data.word_address[ADDR_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    // Write port: the sweep writes empty entries, otherwise the update stage.
    assign ram_we    = r_clr_busy || upd_we;
    assign ram_waddr = r_clr_busy ? r_clr_idx : s1_idx;
    assign ram_wdata = r_clr_busy ? t_entry'('0) : upd;

    // The most recent write is kept to cover a read issued in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (ram_we) begin
            r_fwd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_fwd_idx  <= ram_waddr;
            r_fwd_data <= ram_wdata;
        end
    end

    assign cur = (r_fwd_valid && (r_fwd_idx == s1_idx)) ? r_fwd_data : t_entry'(ram_rdata);

    btcf_match u_match (
        .i_cfg       (r_cfg),
        .i_direction (r_s1.direction),
        .i_address   (r_s1.word_address),
        .o_pass      (pass)
    );

    assign is_wr    = !r_s1.direction[DIR_READ_BIT];
    assign changing = is_wr && (r_s1.prior_value != r_s1.new_value);
    assign cap_on   = (r_cfg.line_cap != '0) && (r_cnt >= r_cfg.line_cap);
    assign fold     = !changing && cur.seen && (cur.value == r_s1.new_value) &&
                      (cur.ctx == r_s1.context_pc);
    assign cnt_inc  = (r_cnt != SAT_MAX) ? (r_cnt + 32'd1) : r_cnt;

    // Plain access event of the current item.
    always_comb begin
        ev.record_kind   = KIND_EVENT;
        ev.rec_direction = r_s1.direction;
        ev.rec_address   = r_s1.word_address;
        ev.rec_old_value = is_wr ? r_s1.prior_value : r_s1.new_value;
        ev.rec_value     = r_s1.new_value;
        ev.rec_context   = r_s1.context_pc;
        ev.rec_frame     = r_s1.frame_number;
        ev.rec_instr     = r_s1.instr_count;
        ev.rec_repeats   = '0;
        ev.rec_last      = 1'b1;
    end

    // Decision, store update and record building.
    always_comb begin
        n_cnt      = r_cnt;
        upd_we     = 1'b0;
        upd        = cur;
        push.count = 2'd0;
        push.rec0  = ev;
        push.rec1  = ev;
        if (s1_fire && pass) begin
            if (cap_on) begin
                // Cap notice only when the count sits exactly at the cap.
                if (r_cnt == r_cfg.line_cap) begin
                    n_cnt                  = cnt_inc;
                    push.count             = 2'd1;
                    push.rec0.record_kind  = KIND_CAP;
                    push.rec0.rec_old_value = '0;
                    push.rec0.rec_value    = '0;
                end
            end else if (r_cfg.raw_mode) begin
                n_cnt      = cnt_inc;
                push.count = 2'd1;
            end else if (fold) begin
                // Repeat of the stored value and context: extend the run.
                upd_we  = 1'b1;
                upd.run = (cur.run != SAT_MAX) ? (cur.run + 32'd1) : cur.run;
            end else begin
                n_cnt      = cnt_inc;
                upd_we     = 1'b1;
                upd.seen   = 1'b1;
                upd.run    = changing ? 32'd0 : 32'd1;
                upd.dir    = r_s1.direction;
                upd.ctx    = r_s1.context_pc;
                upd.value  = r_s1.new_value;
                if (cur.run > 32'd1) begin
                    // Close the previous run with a summary ahead of the event.
                    push.count              = 2'd2;
                    push.rec0.record_kind   = KIND_SUMMARY;
                    push.rec0.rec_direction = cur.dir;
                    push.rec0.rec_old_value = cur.value;
                    push.rec0.rec_value     = cur.value;
                    push.rec0.rec_context   = cur.ctx;
                    push.rec0.rec_repeats   = cur.run;
                    push.rec0.rec_last      = 1'b0;
                end else begin
                    push.count = 2'd1;
                end
            end
        end
    end

    btcf_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space2 (q_space2),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_data   (o_out_data)
    );

endmodule

/* dv/tb.sv */
// Self-checking testbench of the bus trace change filter: directed and random traffic.
`timescale 1ns / 1ps
module tb;
    import btcf_pkg::*;

    // Direction codes of a bus access.
    localparam logic [1:0] DIR_ARM_WR = 2'd0;
    localparam logic [1:0] DIR_ARM_RD = 2'd1;
    localparam logic [1:0] DIR_DSP_WR = 2'd2;
    localparam logic [1:0] DIR_DSP_RD = 2'd3;

    // Trace mode codes that trace both reads and writes.
    localparam logic [1:0] TM_ALL     = 2'd0;
    localparam logic [1:0] TM_ALL_ALT = 2'd3;

    // Receiver stall styles.
    localparam int STALL_NONE     = 0;
    localparam int STALL_LIGHT    = 1;
    localparam int STALL_HEAVY    = 2;
    localparam int STALL_PERIODIC = 3;

    localparam int ITEM_TARGET  = 1000;
    localparam int SETTLE_ticks = 8;

    // Tracks the filter state and holds the trace records still due.
    class trace_tracker;
        logic [1:0]  trace_mode;
        logic        only_listed;
        logic        raw_mode;
        logic [31:0] line_cap;
        logic [1:0]  range_count;
        logic [31:0] ranges [RANGE_REGS];
        logic [31:0] emitted;
        bit          seen      [STORE_DEPTH];
        bit [15:0]   fold_value[STORE_DEPTH];
        bit [31:0]   fold_ctx  [STORE_DEPTH];
        bit [1:0]    fold_dir  [STORE_DEPTH];
        bit [31:0]   fold_run  [STORE_DEPTH];
        t_rec        due_records[$];
        int          bad_records;

        function new();
            trace_mode  = TM_ALL;
            only_listed = 1'b0;
            raw_mode    = 1'b0;
            line_cap    = CAP_RESET;
            range_count = 2'd0;
            foreach (ranges[i]) ranges[i] = 32'd0;
            emitted     = 32'd0;
            bad_records = 0;
        endfunction

        // Mirrors one register write of the configuration port.
        function void write_reg(t_cfg_idx idx, logic [31:0] d);
            case (idx)
                REG_TRACE_MODE:  trace_mode  = d[1:0];
                REG_ONLY_LISTED: only_listed = d[0];
                REG_RAW_MODE:    raw_mode    = d[0];
                REG_LINE_CAP:    line_cap    = d;
                REG_RANGE_COUNT: range_count = d[1:0];
                REG_RANGE_A:     ranges[0]   = d;
                REG_RANGE_B:     ranges[1]   = d;
                REG_RANGE_C:     ranges[2]   = d;
                default: ;
            endcase
        endfunction

        // Address match against the active extra ranges and the fixed window.
        function bit addr_match(logic [15:0] a);
            int n;
            int i;
            logic [15:0] b0, b1, lo, hi;
            n = (range_count > NUM_RANGES) ? NUM_RANGES : int'(range_count);
            for (i = 0; i < n; i++) begin
                b0 = ranges[i][15:0];
                b1 = ranges[i][31:16];
                lo = (b0 < b1) ? b0 : b1;
                hi = (b0 < b1) ? b1 : b0;
                if (a >= lo && a <= hi) return 1'b1;
            end
            if (only_listed) return 1'b0;
            return (a >= WIN_LO && a <= WIN_HI);
        endfunction

        function bit passes(t_acc a);
            logic is_rd;
            is_rd = a.direction[DIR_READ_BIT];
            if (!is_rd && trace_mode == TM_READS_ONLY) return 1'b0;
            if (is_rd && trace_mode == TM_WRITES_ONLY) return 1'b0;
            return addr_match(a.word_address);
        endfunction

        function void count_record();
            if (emitted != SAT_MAX) emitted++;
        endfunction

        function t_rec make_rec(logic [1:0] kind, logic [1:0] dir, logic [15:0] addr,
                                logic [15:0] oldv, logic [15:0] val, logic [31:0] ctx,
                                logic [31:0] fr, logic [31:0] ins, logic [31:0] rep);
            t_rec r;
            r.record_kind   = kind;
            r.rec_direction = dir;
            r.rec_address   = addr;
            r.rec_old_value = oldv;
            r.rec_value     = val;
            r.rec_context   = ctx;
            r.rec_frame     = fr;
            r.rec_instr     = ins;
            r.rec_repeats   = rep;
            r.rec_last      = 1'b0;
            return r;
        endfunction

        // Works out the records that one accepted access causes.
        function void take_access(t_acc a);
            int   idx;
            logic is_wr;
            logic changing;
            t_rec r;
            if (!passes(a)) return;
            is_wr    = !a.direction[DIR_READ_BIT];
            changing = is_wr && (a.prior_value != a.new_value);

            // Cap reached: one notice exactly when the count equals the cap.
            if (line_cap != 32'd0 && emitted >= line_cap) begin
                if (emitted != line_cap) return;
                count_record();
                r = make_rec(KIND_CAP, a.direction, a.word_address, 16'd0, 16'd0,
                             a.context_pc, a.frame_number, a.instr_count, 32'd0);
                r.rec_last = 1'b1;
                due_records.push_back(r);
                return;
            end

            // Raw mode leaves the folding store alone.
            if (raw_mode) begin
                count_record();
                r = make_rec(KIND_EVENT, a.direction, a.word_address,
                             is_wr ? a.prior_value : a.new_value, a.new_value,
                             a.context_pc, a.frame_number, a.instr_count, 32'd0);
                r.rec_last = 1'b1;
                due_records.push_back(r);
                return;
            end

            // A repeat of the stored value and context only extends the run.
            idx = int'(a.word_address) % STORE_DEPTH;
            if (!changing && seen[idx] && fold_value[idx] == a.new_value &&
                fold_ctx[idx] == a.context_pc) begin
                if (fold_run[idx] != SAT_MAX) fold_run[idx]++;
                return;
            end

            count_record();
            if (fold_run[idx] > 32'd1) begin
                due_records.push_back(make_rec(KIND_SUMMARY, fold_dir[idx], a.word_address,
                                               fold_value[idx], fold_value[idx],
                                               fold_ctx[idx], a.frame_number,
                                               a.instr_count, fold_run[idx]));
            end
            fold_run[idx]   = changing ? 32'd0 : 32'd1;
            fold_value[idx] = a.new_value;
            fold_ctx[idx]   = a.context_pc;
            fold_dir[idx]   = a.direction;
            seen[idx]       = 1'b1;
            r = make_rec(KIND_EVENT, a.direction, a.word_address,
                         is_wr ? a.prior_value : a.new_value, a.new_value,
                         a.context_pc, a.frame_number, a.instr_count, 32'd0);
            r.rec_last = 1'b1;
            due_records.push_back(r);
        endfunction

        function string show(t_rec r);
            return $sformatf({"kind=%0d dir=%0d addr=%h old=%h val=%h ctx=%h ",
                              "frame=%h instr=%h rep=%0d last=%b"},
                             r.record_kind, r.rec_direction, r.rec_address,
                             r.rec_old_value, r.rec_value, r.rec_context, r.rec_frame,
                             r.rec_instr, r.rec_repeats, r.rec_last);
        endfunction

        function void complain(string msg);
            bad_records++;
            if (bad_records <= 10) $display("ERROR at %0t: %s", $time, msg);
        endfunction

        // Compares one transferred record with the oldest one due.
        function void match_record(t_rec got);
            t_rec  want;
            string diffs;
            if (due_records.size() == 0) begin
                complain({"record with none due: ", show(got)});
                return;
            end
            want  = due_records.pop_front();
            diffs = "";
            if (got.record_kind   !== want.record_kind)   diffs = {diffs, " kind"};
            if (got.rec_direction !== want.rec_direction) diffs = {diffs, " direction"};
            if (got.rec_address   !== want.rec_address)   diffs = {diffs, " address"};
            if (got.rec_old_value !== want.rec_old_value) diffs = {diffs, " old_value"};
            if (got.rec_value     !== want.rec_value)     diffs = {diffs, " value"};
            if (got.rec_context   !== want.rec_context)   diffs = {diffs, " context"};
            if (got.rec_frame     !== want.rec_frame)     diffs = {diffs, " frame"};
            if (got.rec_instr     !== want.rec_instr)     diffs = {diffs, " instr"};
            if (got.rec_repeats   !== want.rec_repeats)   diffs = {diffs, " repeats"};
            if (got.rec_last      !== want.rec_last)      diffs = {diffs, " last"};
            if (diffs != "") begin
                complain($sformatf("mismatch in%s\n    expected %s\n    actual   %s",
                                   diffs, show(want), show(got)));
            end
        endfunction

        function int pending();
            return due_records.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    t_acc        i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_rec        o_out_data;

    trace_tracker book;

    bus_trace_change_filter u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Every record transfer is checked at the clock edge that moves it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) book.match_record(o_out_data);
    end

    // Output stall: each style is held for a random span before another is drawn; the styles include no stall at all.
    initial begin
        int style;
        int left;
        style       = STALL_NONE;
        left        = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (left == 0) begin
                style = $urandom_range(STALL_PERIODIC, STALL_NONE);
                left  = $urandom_range(200, 20);
            end
            left--;
            case (style)
                STALL_NONE:  i_out_stall = 1'b0;
                STALL_LIGHT: i_out_stall = ($urandom_range(3, 0) == 0);
                STALL_HEAVY: i_out_stall = ($urandom_range(9, 0) < 6);
                default:     i_out_stall = ((left % 4) != 0);
            endcase
        end
    end

    // Writes one configuration register and mirrors it in the tracker.
    task automatic write_cfg(t_cfg_idx idx, logic [31:0] d);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = d;
        @(posedge i_clk);
        book.write_reg(idx, d);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Offers one access and waits for its transfer.
    task automatic send_access(t_acc a);
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data  = a;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        book.take_access(a);
    endtask

    task automatic pause_inputs(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
    endtask

    // Stops sending until every due record has come (or the wait limit runs out) and the pipeline is quiet.
    task automatic drain(int limit);
        int waited;
        waited = 0;
        pause_inputs(1);
        while (book.pending() > 0 && waited < limit) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_ticks) @(posedge i_clk);
    endtask

    function automatic t_acc mk_acc(logic [1:0] dir, logic [15:0] addr, logic [15:0] nv,
                                    logic [15:0] pv, logic [31:0] ctx);
        t_acc a;
        a.direction    = dir;
        a.word_address = addr;
        a.new_value    = nv;
        a.prior_value  = pv;
        a.context_pc   = ctx;
        a.frame_number = $urandom;
        a.instr_count  = $urandom;
        return a;
    endfunction

    // Finds an address inside the window or an active range, bounds often; after 32 misses it returns a random one.
    function automatic logic [15:0] pick_match_addr();
        logic [15:0] cand, b0, b1, lo, hi;
        int area;
        int t;
        for (t = 0; t < 32; t++) begin
            area = $urandom_range(3, 0);
            if (area == 0) begin
                lo = WIN_LO;
                hi = WIN_HI;
            end else begin
                b0 = book.ranges[area-1][15:0];
                b1 = book.ranges[area-1][31:16];
                lo = (b0 < b1) ? b0 : b1;
                hi = (b0 < b1) ? b1 : b0;
            end
            case ($urandom_range(5, 0))
                0:       cand = lo;
                1:       cand = hi;
                default: cand = 16'($urandom_range(hi, lo));
            endcase
            if (book.addr_match(cand)) return cand;
        end
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] random_range_reg();
        logic [15:0] base;
        logic [15:0] other;
        base = 16'($urandom);
        case ($urandom_range(3, 0))
            0: return {16'hFFFF, 16'h0000};
            1: begin
                other = base + 16'($urandom_range(255, 0));
                return ($urandom_range(1, 0) != 0) ? {base, other} : {other, base};
            end
            2: return $urandom;
            default: return {base, base};
        endcase
    endfunction

    // Picks a new setting of every register, the extremes included.
    task automatic configure_phase();
        logic [31:0] cap;
        write_cfg(REG_TRACE_MODE, 32'($urandom_range(3, 0)));
        write_cfg(REG_ONLY_LISTED, 32'($urandom_range(3, 0) == 0));
        write_cfg(REG_RAW_MODE, 32'($urandom_range(4, 0) == 0));
        write_cfg(REG_RANGE_COUNT, 32'($urandom_range(3, 0)));
        write_cfg(REG_RANGE_A, random_range_reg());
        write_cfg(REG_RANGE_B, random_range_reg());
        write_cfg(REG_RANGE_C, random_range_reg());
        case ($urandom_range(9, 0))
            0:       cap = book.emitted + 32'($urandom_range(20, 1));
            1:       cap = book.emitted >> 1;
            2:       cap = SAT_MAX;
            3:       cap = $urandom;
            4:       cap = CAP_RESET;
            default: cap = 32'd0;
        endcase
        write_cfg(REG_LINE_CAP, cap);
    endtask

    // Main sequence: reset, directed cases, then random phases.
    initial begin
        logic [15:0] hot_addr [6];
        logic [15:0] hot_val  [3];
        logic [31:0] hot_ctx  [3];
        t_acc a;
        int   total_sent;
        int   phase;
        int   n_phase;
        int   n_here;
        int   burst_left;
        bit   no_gaps;
        int   k;

        book       = new();
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_TRACE_MODE;
        i_cfg_data = 32'd0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: folding of reads and no-effect writes in the fixed window, then accesses outside it.
        send_access(mk_acc(DIR_ARM_WR, WIN_LO, 16'hFFFF, 16'h0000, 32'h0));
        send_access(mk_acc(DIR_ARM_RD, WIN_LO, 16'hFFFF, 16'h0000, 32'h0));
        send_access(mk_acc(DIR_DSP_RD, WIN_LO, 16'hFFFF, 16'hFFFF, 32'h0));
        send_access(mk_acc(DIR_DSP_RD, WIN_LO, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF));
        send_access(mk_acc(DIR_DSP_WR, WIN_HI, 16'h1234, 16'h1234, 32'h5555_AAAA));
        send_access(mk_acc(DIR_DSP_WR, WIN_HI, 16'h1234, 16'h1234, 32'h5555_AAAA));
        send_access(mk_acc(DIR_ARM_WR, WIN_HI, 16'h1234, 16'hFFFF, 32'h5555_AAAA));
        send_access(mk_acc(DIR_ARM_RD, WIN_HI, 16'h1234, 16'h0000, 32'h5555_AAAA));
        send_access(mk_acc(DIR_ARM_RD, WIN_HI, 16'h0000, 16'h0000, 32'h5555_AAAA));
        send_access(mk_acc(DIR_ARM_RD, WIN_LO - 16'd1, 16'h0001, 16'h0000, 32'h1));
        send_access(mk_acc(DIR_DSP_WR, WIN_HI + 16'd1, 16'h0001, 16'h0000, 32'h1));
        send_access(mk_acc(DIR_DSP_RD, 16'hFFFF, 16'h0001, 16'h0000, 32'h1));
        drain(20000);

        // Writes only, listed ranges only, bounds given in both orders.
        write_cfg(REG_TRACE_MODE, 32'(TM_WRITES_ONLY));
        write_cfg(REG_ONLY_LISTED, 32'd1);
        write_cfg(REG_RANGE_COUNT, 32'd3);
        write_cfg(REG_RANGE_A, {16'h0000, 16'h0010});
        write_cfg(REG_RANGE_B, {16'hFFFF, 16'hFFF0});
        write_cfg(REG_RANGE_C, 32'h8000_8000);
        send_access(mk_acc(DIR_ARM_WR, 16'h0000, 16'h00FF, 16'h0000, 32'h10));
        send_access(mk_acc(DIR_ARM_RD, 16'h0005, 16'h00FF, 16'h0000, 32'h10));
        send_access(mk_acc(DIR_DSP_WR, 16'hFFFF, 16'hA5A5, 16'h5A5A, 32'h20));
        send_access(mk_acc(DIR_ARM_WR, 16'h8000, 16'h0001, 16'h0002, 32'h30));
        send_access(mk_acc(DIR_ARM_WR, WIN_LO, 16'h0003, 16'h0004, 32'h40));
        send_access(mk_acc(DIR_DSP_WR, 16'h0011, 16'h0003, 16'h0004, 32'h40));
        drain(20000);

        // Reads only in raw mode: repeats are not folded.
        write_cfg(REG_TRACE_MODE, 32'(TM_READS_ONLY));
        write_cfg(REG_RAW_MODE, 32'd1);
        send_access(mk_acc(DIR_ARM_RD, 16'h0010, 16'h0007, 16'h0000, 32'h1));
        send_access(mk_acc(DIR_ARM_RD, 16'h0010, 16'h0007, 16'h0000, 32'h1));
        send_access(mk_acc(DIR_DSP_WR, 16'h0010, 16'h0007, 16'h0008, 32'h1));
        drain(20000);

        // Cap two records ahead: two events, one notice, then silence.
        write_cfg(REG_TRACE_MODE, 32'(TM_ALL_ALT));
        write_cfg(REG_RAW_MODE, 32'd0);
        write_cfg(REG_LINE_CAP, book.emitted + 32'd2);
        for (k = 0; k < 4; k++) begin
            send_access(mk_acc(DIR_DSP_WR, 16'hFFF0, 16'(k), ~16'(k), 32'h99));
        end
        drain(20000);

        // Cap lowered below the count: nothing at all.
        write_cfg(REG_LINE_CAP, 32'd1);
        send_access(mk_acc(DIR_ARM_WR, 16'hFFF1, 16'h0001, 16'h0002, 32'h99));
        drain(20000);

        // Random phases: mostly hot addresses with small value and context pools.
        total_sent = 0;
        phase      = 0;
        while (total_sent < ITEM_TARGET && phase < 60) begin
            drain(20000);
            configure_phase();
            foreach (hot_addr[i]) hot_addr[i] = pick_match_addr();
            hot_val[0] = 16'($urandom);
            hot_val[1] = 16'($urandom);
            hot_val[2] = ($urandom_range(1, 0) != 0) ? 16'hFFFF : 16'h0000;
            hot_ctx[0] = $urandom;
            hot_ctx[1] = $urandom;
            hot_ctx[2] = ($urandom_range(1, 0) != 0) ? 32'hFFFF_FFFF : 32'h0;
            no_gaps    = ($urandom_range(5, 0) == 0);
            n_phase    = $urandom_range(160, 60);
            n_here     = 0;
            burst_left = $urandom_range(16, 1);
            while (n_here < n_phase) begin
                if ($urandom_range(9, 0) < 8) begin
                    a = mk_acc(2'($urandom_range(3, 0)), hot_addr[$urandom_range(5, 0)],
                               hot_val[$urandom_range(2, 0)], 16'($urandom),
                               hot_ctx[$urandom_range(2, 0)]);
                    if ($urandom_range(1, 0) != 0) a.prior_value = a.new_value;
                end else begin
                    a = mk_acc(2'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                               $urandom);
                end
                n_here++;
                total_sent++;
                send_access(a);
                burst_left--;
                if (burst_left == 0) begin
                    if (!no_gaps) pause_inputs($urandom_range(6, 0));
                    burst_left = $urandom_range(16, 1);
                end
                if ($urandom_range(255, 0) == 0) drain(20000);
            end
            phase++;
        end

        drain(20000);
        repeat (20) @(posedge i_clk);
        if (book.pending() > 0) book.complain($sformatf("%0d records never came", book.pending()));
        if (book.bad_records == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

/* sim.f */
rtl/btcf_pkg.sv
rtl/btcf_ram.sv
rtl/btcf_match.sv
rtl/btcf_outq.sv
rtl/bus_trace_change_filter.sv
dv/tb.sv
